// ===== rtl/core/ccblit_pkg.sv =====
// Package for the clipped color-key blitter.
// Field widths, register indexes, mode codes, reset values and the input item record.
// Used by clipped_colorkey_blit, ccblit_checker and tb_top; depends on nothing.
package ccblit_pkg;

	localparam int COORD_W      = 16;
	localparam int CLIP_W       = 19;
	localparam int PIX_W        = 32;
	localparam int OFF_W        = 25;
	localparam int CFG_W        = 32;
	localparam int IDX_W        = 3;
	localparam int DIM_REG_W    = 13;
	localparam int STRIDE_REG_W = 14;

	localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_DST_STRIDE = 3'd2;
	localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd3;
	localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd4;
	localparam logic [IDX_W-1:0] REG_SRC_STRIDE = 3'd5;
	localparam logic [IDX_W-1:0] REG_KEY_COLOR  = 3'd6;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;

	localparam logic [DIM_REG_W-1:0]    RST_WIDTH  = 13'd640;
	localparam logic [DIM_REG_W-1:0]    RST_HEIGHT = 13'd480;
	localparam logic [STRIDE_REG_W-1:0] RST_STRIDE = 14'd640;

	typedef struct packed {
		logic                      mode;
		logic signed [COORD_W-1:0] dest_x;
		logic signed [COORD_W-1:0] dest_y;
		logic signed [COORD_W-1:0] source_x;
		logic signed [COORD_W-1:0] source_y;
		logic signed [COORD_W-1:0] rect_w;
		logic signed [COORD_W-1:0] rect_h;
		logic                      key_enable;
		logic [PIX_W-1:0]          pixel;
	} in_item_t;

endpackage

// ===== rtl/core/clipped_colorkey_blit.sv =====
// Clipped color-key blitter: an accepted item is first held in the input register.
// Throughput is one item per clock without out_stall; the clip chain and the counter step
// share one stage, then stride multiply and offset add stages lead to the output register.
// While a result waits at the output, the ready chain lets empty stages keep taking items.
// Reset idles the engine, clears the walk state and loads the default surface registers.
// Depends on ccblit_pkg.
module clipped_colorkey_blit
	import ccblit_pkg::*;
#(
	parameter int MAX_DIM    = 4096,
	parameter int MAX_STRIDE = 8192
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      mode,
	input  logic signed [COORD_W-1:0] dest_x,
	input  logic signed [COORD_W-1:0] dest_y,
	input  logic signed [COORD_W-1:0] source_x,
	input  logic signed [COORD_W-1:0] source_y,
	input  logic signed [COORD_W-1:0] rect_w,
	input  logic signed [COORD_W-1:0] rect_h,
	input  logic                      key_enable,
	input  logic [PIX_W-1:0]          pixel,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      read_valid,
	output logic [OFF_W-1:0]          read_offset,
	output logic                      write_valid,
	output logic [OFF_W-1:0]          write_offset,
	output logic [PIX_W-1:0]          write_data,
	output logic                      last,
	output logic                      rejected
);

	localparam int AW  = $clog2(MAX_DIM);
	localparam int SW  = $clog2(MAX_STRIDE + 1);
	localparam int SCW = (SW > STRIDE_REG_W) ? SW : STRIDE_REG_W;
	localparam int PW  = AW + SW + 1;

	typedef struct packed {
		logic             rv;
		logic [AW-1:0]    src_y;
		logic [AW-1:0]    src_x;
		logic             wv;
		logic             wr_en;
		logic [AW-1:0]    dst_y;
		logic [AW-1:0]    dst_x;
		logic [PIX_W-1:0] data;
		logic             last;
		logic             rej;
	} s2_t;

	typedef struct packed {
		logic             rv;
		logic [AW+SW-1:0] src_prod;
		logic [AW-1:0]    src_x;
		logic             wv;
		logic             wr_en;
		logic [AW+SW-1:0] dst_prod;
		logic [AW-1:0]    dst_x;
		logic [PIX_W-1:0] data;
		logic             last;
		logic             rej;
	} s3_t;

	typedef struct packed {
		logic             read_valid;
		logic [OFF_W-1:0] read_offset;
		logic             write_valid;
		logic [OFF_W-1:0] write_offset;
		logic [PIX_W-1:0] write_data;
		logic             last;
		logic             rejected;
	} out_t;

	function automatic logic signed [CLIP_W-1:0] sext(input logic [COORD_W-1:0] v);
		return signed'({{(CLIP_W-COORD_W){v[COORD_W-1]}}, v});
	endfunction

	function automatic logic signed [CLIP_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
		logic [CLIP_W-1:0] x;
		logic [CLIP_W-1:0] lim;
		x   = {{(CLIP_W-DIM_REG_W){1'b0}}, v};
		lim = CLIP_W'(MAX_DIM);
		return signed'((x > lim) ? lim : x);
	endfunction

	function automatic logic [SW-1:0] clamp_stride(input logic [STRIDE_REG_W-1:0] v);
		logic [SCW-1:0] x;
		logic [SCW-1:0] lim;
		x   = SCW'(v);
		lim = SCW'(MAX_STRIDE);
		return SW'((x > lim) ? lim : x);
	endfunction

	logic [DIM_REG_W-1:0]    dst_width_q, dst_height_q, src_width_q, src_height_q;
	logic [STRIDE_REG_W-1:0] dst_stride_q, src_stride_q;
	logic [PIX_W-1:0]        key_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_width_q  <= RST_WIDTH;
			dst_height_q <= RST_HEIGHT;
			dst_stride_q <= RST_STRIDE;
			src_width_q  <= RST_WIDTH;
			src_height_q <= RST_HEIGHT;
			src_stride_q <= RST_STRIDE;
			key_color_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DST_WIDTH:  dst_width_q  <= cfg_data[DIM_REG_W-1:0];
				REG_DST_HEIGHT: dst_height_q <= cfg_data[DIM_REG_W-1:0];
				REG_DST_STRIDE: dst_stride_q <= cfg_data[STRIDE_REG_W-1:0];
				REG_SRC_WIDTH:  src_width_q  <= cfg_data[DIM_REG_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[DIM_REG_W-1:0];
				REG_SRC_STRIDE: src_stride_q <= cfg_data[STRIDE_REG_W-1:0];
				REG_KEY_COLOR:  key_color_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic adv1, adv2, adv3;
	in_item_t item_s1;
	s2_t      st_s2, st2_d;
	s3_t      st_s3;
	out_t     out_s4;

	assign rdy4     = !v_s4 || !out_stall;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;
	assign adv1     = v_s1 && rdy2;
	assign adv2     = v_s2 && rdy3;
	assign adv3     = v_s3 && rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			item_s1 <= '{mode: mode, dest_x: dest_x, dest_y: dest_y, source_x: source_x,
				source_y: source_y, rect_w: rect_w, rect_h: rect_h,
				key_enable: key_enable, pixel: pixel};
		end
	end

	logic          busy_q, keying_q;
	logic [AW-1:0] clip_dx_q, clip_dy_q, clip_sx_q, clip_sy_q;
	logic [AW:0]   clip_w_q, clip_h_q;
	logic [AW-1:0] col_q, row_q;

	logic signed [CLIP_W-1:0] ddx, ddy, ssx, ssy, ww, hh;
	logic signed [CLIP_W-1:0] dw, dh, sw, sh;
	logic                     ok0, ok1, clip_ok;

	always_comb begin
		dw  = clamp_dim(dst_width_q);
		dh  = clamp_dim(dst_height_q);
		sw  = clamp_dim(src_width_q);
		sh  = clamp_dim(src_height_q);
		ddx = sext(item_s1.dest_x);
		ddy = sext(item_s1.dest_y);
		ssx = sext(item_s1.source_x);
		ssy = sext(item_s1.source_y);
		ww  = sext(item_s1.rect_w);
		hh  = sext(item_s1.rect_h);
		ok0 = (ww > 0) && (hh > 0);
		if (ddx < 0) begin
			ww  = ww + ddx;
			ssx = ssx - ddx;
			ddx = '0;
		end
		if (ddy < 0) begin
			hh  = hh + ddy;
			ssy = ssy - ddy;
			ddy = '0;
		end
		if (ssx < 0) begin
			ww  = ww + ssx;
			ddx = ddx - ssx;
			ssx = '0;
		end
		if (ssy < 0) begin
			hh  = hh + ssy;
			ddy = ddy - ssy;
			ssy = '0;
		end
		ok1 = (ww > 0) && (hh > 0);
		if (ddx + ww > dw) ww = dw - ddx;
		if (ddy + hh > dh) hh = dh - ddy;
		if (ssx + ww > sw) ww = sw - ssx;
		if (ssy + hh > sh) hh = sh - ssy;
		clip_ok = ok0 && ok1 && (ww > 0) && (hh > 0);
	end

	logic [AW:0]   col_inc, row_inc, row_nf;
	logic          wrap, done;
	logic [AW-1:0] col_n, row_n;

	always_comb begin
		col_inc = {1'b0, col_q} + 1'b1;
		row_inc = {1'b0, row_q} + 1'b1;
		wrap    = col_inc >= clip_w_q;
		col_n   = wrap ? '0 : col_inc[AW-1:0];
		row_nf  = wrap ? row_inc : {1'b0, row_q};
		done    = row_nf >= clip_h_q;
		row_n   = row_nf[AW-1:0];
	end

	always_comb begin
		st2_d = '0;
		if (item_s1.mode == MODE_START) begin
			if (clip_ok) begin
				st2_d.rv    = 1'b1;
				st2_d.src_y = ssy[AW-1:0];
				st2_d.src_x = ssx[AW-1:0];
			end else begin
				st2_d.last = 1'b1;
				st2_d.rej  = 1'b1;
			end
		end else if (busy_q) begin
			st2_d.wr_en = 1'b1;
			st2_d.wv    = !(keying_q && (item_s1.pixel == key_color_q));
			st2_d.dst_y = clip_dy_q + row_q;
			st2_d.dst_x = clip_dx_q + col_q;
			st2_d.data  = item_s1.pixel;
			if (done) begin
				st2_d.last = 1'b1;
			end else begin
				st2_d.rv    = 1'b1;
				st2_d.src_y = clip_sy_q + row_n;
				st2_d.src_x = clip_sx_q + col_n;
			end
		end else begin
			st2_d.last = 1'b1;
			st2_d.rej  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			keying_q  <= 1'b0;
			clip_dx_q <= '0;
			clip_dy_q <= '0;
			clip_sx_q <= '0;
			clip_sy_q <= '0;
			clip_w_q  <= '0;
			clip_h_q  <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else if (adv1) begin
			if (item_s1.mode == MODE_START) begin
				busy_q <= clip_ok;
				if (clip_ok) begin
					clip_dx_q <= ddx[AW-1:0];
					clip_dy_q <= ddy[AW-1:0];
					clip_sx_q <= ssx[AW-1:0];
					clip_sy_q <= ssy[AW-1:0];
					clip_w_q  <= ww[AW:0];
					clip_h_q  <= hh[AW:0];
					col_q     <= '0;
					row_q     <= '0;
					keying_q  <= item_s1.key_enable;
				end
			end else if (busy_q) begin
				if (done) begin
					busy_q <= 1'b0;
					col_q  <= '0;
					row_q  <= '0;
				end else begin
					col_q <= col_n;
					row_q <= row_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) st_s2 <= st2_d;
	end

	logic [SW-1:0] src_stride_c, dst_stride_c;
	assign src_stride_c = clamp_stride(src_stride_q);
	assign dst_stride_c = clamp_stride(dst_stride_q);

	always_ff @(posedge clk) begin
		if (adv2) begin
			st_s3.rv       <= st_s2.rv;
			st_s3.src_prod <= {{SW{1'b0}}, st_s2.src_y} * {{AW{1'b0}}, src_stride_c};
			st_s3.src_x    <= st_s2.src_x;
			st_s3.wv       <= st_s2.wv;
			st_s3.wr_en    <= st_s2.wr_en;
			st_s3.dst_prod <= {{SW{1'b0}}, st_s2.dst_y} * {{AW{1'b0}}, dst_stride_c};
			st_s3.dst_x    <= st_s2.dst_x;
			st_s3.data     <= st_s2.data;
			st_s3.last     <= st_s2.last;
			st_s3.rej      <= st_s2.rej;
		end
	end

	logic [PW-1:0] src_sum, dst_sum;
	assign src_sum = {1'b0, st_s3.src_prod} + {{(PW-AW){1'b0}}, st_s3.src_x};
	assign dst_sum = {1'b0, st_s3.dst_prod} + {{(PW-AW){1'b0}}, st_s3.dst_x};

	always_ff @(posedge clk) begin
		if (adv3) begin
			out_s4.read_valid   <= st_s3.rv;
			out_s4.read_offset  <= st_s3.rv ? OFF_W'(src_sum) : '0;
			out_s4.write_valid  <= st_s3.wr_en && st_s3.wv;
			out_s4.write_offset <= st_s3.wr_en ? OFF_W'(dst_sum) : '0;
			out_s4.write_data   <= st_s3.wr_en ? st_s3.data : '0;
			out_s4.last         <= st_s3.last;
			out_s4.rejected     <= st_s3.rej;
		end
	end

	assign out_valid    = v_s4;
	assign read_valid   = out_s4.read_valid;
	assign read_offset  = out_s4.read_offset;
	assign write_valid  = out_s4.write_valid;
	assign write_offset = out_s4.write_offset;
	assign write_data   = out_s4.write_data;
	assign last         = out_s4.last;
	assign rejected     = out_s4.rejected;

	a_rej_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> last)
		else $error("rejected result without last");

	a_read_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(read_valid && last))
		else $error("read requested on final result");

	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ({1'b0, col_q} < clip_w_q) && ({1'b0, row_q} < clip_h_q))
		else $error("walk counters beyond clipped rectangle");

	a_last_idles: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 && st2_d.last |=> !busy_q)
		else $error("engine still busy after final item");

	a_idle_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		adv1 && item_s1.mode == MODE_PIXEL && !busy_q |=> !busy_q)
		else $error("pixel while idle started a walk");

	a_write_not_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_valid |-> !rejected)
		else $error("write on rejected result");

endmodule

// ===== dv/ccblit_checker.sv =====
// Checker for the clipped color-key blitter: predicts every result from the items
// and register writes it sees, and compares accepted results in order.
// Depends on ccblit_pkg; instantiated beside the block by tb_top.
module ccblit_checker
	import ccblit_pkg::*;
#(
	parameter int MAX_DIM    = 4096,
	parameter int MAX_STRIDE = 8192
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [IDX_W-1:0]          cfg_index,
	input  logic [CFG_W-1:0]          cfg_data,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic                      mode,
	input  logic signed [COORD_W-1:0] dest_x,
	input  logic signed [COORD_W-1:0] dest_y,
	input  logic signed [COORD_W-1:0] source_x,
	input  logic signed [COORD_W-1:0] source_y,
	input  logic signed [COORD_W-1:0] rect_w,
	input  logic signed [COORD_W-1:0] rect_h,
	input  logic                      key_enable,
	input  logic [PIX_W-1:0]          pixel,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic                      read_valid,
	input  logic [OFF_W-1:0]          read_offset,
	input  logic                      write_valid,
	input  logic [OFF_W-1:0]          write_offset,
	input  logic [PIX_W-1:0]          write_data,
	input  logic                      last,
	input  logic                      rejected,
	output int                        fails,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             read_valid;
		logic [OFF_W-1:0] read_offset;
		logic             write_valid;
		logic [OFF_W-1:0] write_offset;
		logic [PIX_W-1:0] write_data;
		logic             last;
		logic             rejected;
	} blit_result_t;

	blit_result_t predicted_results[$];

	logic [DIM_REG_W-1:0]    dst_w_reg, dst_h_reg, src_w_reg, src_h_reg;
	logic [STRIDE_REG_W-1:0] dst_stride_reg, src_stride_reg;
	logic [PIX_W-1:0]        key_reg;

	logic    walking, keying;
	longint  clip_dx, clip_dy, clip_sx, clip_sy, clip_w, clip_h, col, row;

	function automatic longint dim_eff(logic [DIM_REG_W-1:0] v);
		return (v > MAX_DIM) ? longint'(MAX_DIM) : longint'(v);
	endfunction

	function automatic longint stride_eff(logic [STRIDE_REG_W-1:0] v);
		return (v > MAX_STRIDE) ? longint'(MAX_STRIDE) : longint'(v);
	endfunction

	function automatic logic [OFF_W-1:0] pixel_index(longint y, longint stride, longint x);
		longint v;
		v = y * stride + x;
		return v[OFF_W-1:0];
	endfunction

	function automatic blit_result_t predict_blit(in_item_t it);
		blit_result_t r;
		longint ddx, ddy, ssx, ssy, ww, hh;
		bit ok;
		r = '0;
		if (it.mode == MODE_START) begin
			ddx = longint'(it.dest_x);
			ddy = longint'(it.dest_y);
			ssx = longint'(it.source_x);
			ssy = longint'(it.source_y);
			ww = longint'(it.rect_w);
			hh = longint'(it.rect_h);
			ok = (ww > 0 && hh > 0);
			walking = 1'b0;
			if (ok) begin
				if (ddx < 0) begin
					ww += ddx; ssx -= ddx; ddx = 0;
				end
				if (ddy < 0) begin
					hh += ddy; ssy -= ddy; ddy = 0;
				end
				if (ssx < 0) begin
					ww += ssx; ddx -= ssx; ssx = 0;
				end
				if (ssy < 0) begin
					hh += ssy; ddy -= ssy; ssy = 0;
				end
				if (ww <= 0 || hh <= 0) ok = 0;
			end
			if (ok) begin
				if (ddx + ww > dim_eff(dst_w_reg)) ww = dim_eff(dst_w_reg) - ddx;
				if (ddy + hh > dim_eff(dst_h_reg)) hh = dim_eff(dst_h_reg) - ddy;
				if (ssx + ww > dim_eff(src_w_reg)) ww = dim_eff(src_w_reg) - ssx;
				if (ssy + hh > dim_eff(src_h_reg)) hh = dim_eff(src_h_reg) - ssy;
				if (ww <= 0 || hh <= 0) ok = 0;
			end
			if (!ok) begin
				r.last = 1'b1;
				r.rejected = 1'b1;
				return r;
			end
			clip_dx = ddx;
			clip_dy = ddy;
			clip_sx = ssx;
			clip_sy = ssy;
			clip_w = ww;
			clip_h = hh;
			col = 0;
			row = 0;
			keying = it.key_enable;
			walking = 1'b1;
			r.read_valid = 1'b1;
			r.read_offset = pixel_index(clip_sy, stride_eff(src_stride_reg), clip_sx);
			return r;
		end
		if (!walking) begin
			r.last = 1'b1;
			r.rejected = 1'b1;
			return r;
		end
		r.write_valid = !(keying && it.pixel == key_reg);
		r.write_offset = pixel_index(clip_dy + row, stride_eff(dst_stride_reg), clip_dx + col);
		r.write_data = it.pixel;
		col++;
		if (col >= clip_w) begin
			col = 0;
			row++;
		end
		if (row >= clip_h) begin
			walking = 1'b0;
			col = 0;
			row = 0;
			r.last = 1'b1;
		end else begin
			r.read_valid = 1'b1;
			r.read_offset = pixel_index(clip_sy + row, stride_eff(src_stride_reg),
				clip_sx + col);
		end
		return r;
	endfunction

	function automatic void check_field(string name, longint got, longint want);
		if (got != want) begin
			fails++;
			if (fails <= 10)
				$display("%0t mismatch %s: expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		blit_result_t want;
		in_item_t     it;
		if (!arst_n) begin
			dst_w_reg = RST_WIDTH;
			dst_h_reg = RST_HEIGHT;
			dst_stride_reg = RST_STRIDE;
			src_w_reg = RST_WIDTH;
			src_h_reg = RST_HEIGHT;
			src_stride_reg = RST_STRIDE;
			key_reg = '0;
			walking = 1'b0;
			keying = 1'b0;
			clip_dx = 0; clip_dy = 0; clip_sx = 0; clip_sy = 0;
			clip_w = 0; clip_h = 0; col = 0; row = 0;
			predicted_results.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_DST_WIDTH:  dst_w_reg = cfg_data[DIM_REG_W-1:0];
					REG_DST_HEIGHT: dst_h_reg = cfg_data[DIM_REG_W-1:0];
					REG_DST_STRIDE: dst_stride_reg = cfg_data[STRIDE_REG_W-1:0];
					REG_SRC_WIDTH:  src_w_reg = cfg_data[DIM_REG_W-1:0];
					REG_SRC_HEIGHT: src_h_reg = cfg_data[DIM_REG_W-1:0];
					REG_SRC_STRIDE: src_stride_reg = cfg_data[STRIDE_REG_W-1:0];
					REG_KEY_COLOR:  key_reg = cfg_data[PIX_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (predicted_results.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t result with no item outstanding", $time);
				end else begin
					want = predicted_results.pop_front();
					check_field("read_valid", longint'(read_valid),
						longint'(want.read_valid));
					check_field("read_offset", longint'(read_offset),
						longint'(want.read_offset));
					check_field("write_valid", longint'(write_valid),
						longint'(want.write_valid));
					check_field("write_offset", longint'(write_offset),
						longint'(want.write_offset));
					check_field("write_data", longint'(write_data),
						longint'(want.write_data));
					check_field("last", longint'(last), longint'(want.last));
					check_field("rejected", longint'(rejected), longint'(want.rejected));
				end
			end
			if (in_valid && !in_stall) begin
				it.mode = mode;
				it.dest_x = dest_x;
				it.dest_y = dest_y;
				it.source_x = source_x;
				it.source_y = source_y;
				it.rect_w = rect_w;
				it.rect_h = rect_h;
				it.key_enable = key_enable;
				it.pixel = pixel;
				predicted_results.push_back(predict_blit(it));
			end
			pending = predicted_results.size();
		end
	end

endmodule

// ===== dv/tb_top.sv =====
// Top of the clipped color-key blitter testbench: clock, reset, register setup,
// directed and random blit traffic with idle gaps and stalls, watchdog and verdict.
// Depends on ccblit_pkg, clipped_colorkey_blit and ccblit_checker.
module tb_top;
	import ccblit_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_DIM        = 4096;
	localparam int MAX_STRIDE     = 8192;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 300;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_write = 1'b0;
	logic [IDX_W-1:0]          cfg_index = '0;
	logic [CFG_W-1:0]          cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic                      mode = MODE_START;
	logic signed [COORD_W-1:0] dest_x = '0;
	logic signed [COORD_W-1:0] dest_y = '0;
	logic signed [COORD_W-1:0] source_x = '0;
	logic signed [COORD_W-1:0] source_y = '0;
	logic signed [COORD_W-1:0] rect_w = '0;
	logic signed [COORD_W-1:0] rect_h = '0;
	logic                      key_enable = 1'b0;
	logic [PIX_W-1:0]          pixel = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic                      read_valid;
	logic [OFF_W-1:0]          read_offset;
	logic                      write_valid;
	logic [OFF_W-1:0]          write_offset;
	logic [PIX_W-1:0]          write_data;
	logic                      last;
	logic                      rejected;
	int                        fails;
	int                        pending;

	int               items_sent = 0;
	int               gap_pct = 14;
	int               stall_pct = 14;
	bit               hold_req = 1'b0;
	int               dw_eff, dh_eff, sw_eff, sh_eff;
	logic [PIX_W-1:0] key_now;

	clipped_colorkey_blit #(.MAX_DIM(MAX_DIM), .MAX_STRIDE(MAX_STRIDE)) dut (.*);
	ccblit_checker #(.MAX_DIM(MAX_DIM), .MAX_STRIDE(MAX_STRIDE)) chk (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int usable_dim(int v);
		return (v > MAX_DIM) ? MAX_DIM : v;
	endfunction

	function automatic in_item_t make_start(int dx, int dy, int sx, int sy, int w, int h,
			bit ke);
		in_item_t it;
		it.mode = MODE_START;
		it.dest_x = COORD_W'(dx);
		it.dest_y = COORD_W'(dy);
		it.source_x = COORD_W'(sx);
		it.source_y = COORD_W'(sy);
		it.rect_w = COORD_W'(w);
		it.rect_h = COORD_W'(h);
		it.key_enable = ke;
		it.pixel = $urandom();
		return it;
	endfunction

	function automatic in_item_t make_pixel(logic [PIX_W-1:0] px);
		in_item_t it;
		it.mode = MODE_PIXEL;
		it.dest_x = COORD_W'($urandom());
		it.dest_y = COORD_W'($urandom());
		it.source_x = COORD_W'($urandom());
		it.source_y = COORD_W'($urandom());
		it.rect_w = COORD_W'($urandom());
		it.rect_h = COORD_W'($urandom());
		it.key_enable = 1'($urandom_range(1));
		it.pixel = px;
		return it;
	endfunction

	function automatic in_item_t noise_item();
		in_item_t it;
		it = make_pixel($urandom());
		it.mode = $urandom_range(1) ? MODE_PIXEL : MODE_START;
		return it;
	endfunction

	// hold the item until accepted; valid stays high on return
	task automatic send_item(in_item_t it);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= it.mode;
		dest_x <= it.dest_x;
		dest_y <= it.dest_y;
		source_x <= it.source_x;
		source_y <= it.source_y;
		rect_w <= it.rect_w;
		rect_h <= it.rect_h;
		key_enable <= it.key_enable;
		pixel <= it.pixel;
		do @(posedge clk); while (in_stall);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	task automatic set_surfaces(int dw, int dh, int ds, int sw, int sh, int ss,
			logic [PIX_W-1:0] key);
		drain();
		write_reg(REG_DST_WIDTH, dw);
		write_reg(REG_DST_HEIGHT, dh);
		write_reg(REG_DST_STRIDE, ds);
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_SRC_STRIDE, ss);
		write_reg(REG_KEY_COLOR, key);
		cfg_write <= 1'b0;
		@(negedge clk);
		dw_eff = usable_dim(dw);
		dh_eff = usable_dim(dh);
		sw_eff = usable_dim(sw);
		sh_eff = usable_dim(sh);
		key_now = key;
	endtask

	task automatic random_sequence();
		int choice, w, h, wmax, hmax, npix;
		choice = $urandom_range(99);
		if (choice < 10) begin
			send_item(noise_item());
			return;
		end
		wmax = 6;
		if (dw_eff < wmax) wmax = dw_eff;
		if (sw_eff < wmax) wmax = sw_eff;
		hmax = 4;
		if (dh_eff < hmax) hmax = dh_eff;
		if (sh_eff < hmax) hmax = sh_eff;
		if (choice < 75 && wmax > 0 && hmax > 0) begin
			w = $urandom_range(1, wmax);
			h = $urandom_range(1, hmax);
			send_item(make_start($urandom_range(0, dw_eff - w), $urandom_range(0, dh_eff - h),
				$urandom_range(0, sw_eff - w), $urandom_range(0, sh_eff - h), w, h,
				1'($urandom_range(1))));
			npix = w * h;
		end else begin
			w = $urandom_range(1, 8);
			h = $urandom_range(1, 5);
			send_item(make_start(int'($urandom_range(0, dw_eff + 8)) - 6,
				int'($urandom_range(0, dh_eff + 6)) - 4,
				int'($urandom_range(0, sw_eff + 8)) - 6,
				int'($urandom_range(0, sh_eff + 6)) - 4, w, h, 1'($urandom_range(1))));
			npix = ($urandom_range(3) == 0) ? $urandom_range(0, w * h) :
				w * h + $urandom_range(0, 1);
		end
		repeat (npix)
			send_item(make_pixel(($urandom_range(3) == 0) ? key_now : $urandom()));
	endtask

	task automatic random_phase(int n);
		int target;
		target = items_sent + n;
		while (items_sent < target) begin
			if ($urandom_range(99) < 2) drain();
			random_sequence();
		end
	endtask

	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL clipped_colorkey_blit");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_surfaces(16, 12, 20, 10, 8, 12, 32'hDEADBEEF);
		send_item(make_pixel(32'hFFFFFFFF));
		send_item(make_start(0, 0, 0, 0, 0, 5, 1));
		send_item(make_start(0, 0, 0, 0, -32768, 3, 0));
		send_item(make_start(0, 0, 0, 0, 3, -1, 0));
		send_item(make_start(32767, 32767, 32767, 32767, 32767, 32767, 1));
		send_item(make_start(-32768, -32768, -32768, -32768, 32767, 32767, 0));
		send_item(make_start(-2, 0, 0, 0, 4, 1, 1));
		send_item(make_pixel(32'hDEADBEEF));
		send_item(make_pixel(32'h00000000));
		send_item(make_start(3, 0, -1, -3, 2, 5, 1));
		send_item(make_pixel(32'hDEADBEEF));
		send_item(make_pixel(32'h12345678));
		send_item(make_start(0, 0, 0, 0, 32767, 32767, 0));
		send_item(make_pixel(32'hDEADBEEF));
		send_item(make_pixel(32'h0F0F0F0F));
		send_item(make_start(15, 11, 9, 7, 1, 1, 1));
		send_item(make_pixel(32'hFFFFFFFF));
		send_item(make_pixel(32'h00000000));
		send_item(make_start(14, 10, 8, 6, 5, 5, 0));
		send_item(make_pixel(32'h00000000));
		send_item(make_pixel(32'hFFFFFFFF));
		send_item(make_pixel(32'hAAAAAAAA));
		send_item(make_pixel(32'h55555555));
		send_item(make_start(16, 0, 0, 0, 1, 1, 0));
		send_item(make_start(0, 0, 0, 8, 1, 1, 0));

		set_surfaces(24, 18, 32, 20, 16, 20, $urandom());
		random_phase(100);
		hold_req = 1'b1;
		random_phase(300);

		set_surfaces(1, 1, 1, 1, 1, 1, 32'hFFFFFFFF);
		random_phase(200);

		gap_pct = 0;
		stall_pct = 0;
		set_surfaces(4096, 4096, 8192, 4096, 4096, 8192, 32'h0);
		random_phase(210);
		gap_pct = 14;
		stall_pct = 14;

		set_surfaces(8191, 8191, 16383, 8191, 8191, 16383, $urandom());
		random_phase(210);

		set_surfaces(37, 29, 0, 33, 40, 0, $urandom());
		random_phase(210);

		set_surfaces(0, 480, 640, 640, 0, 640, $urandom());
		random_phase(100);

		set_surfaces(640, 480, 300, 100, 50, 7, $urandom());
		random_phase(210);

		drain();
		repeat (10) @(negedge clk);
		if (fails == 0 && pending == 0)
			$display("PASS clipped_colorkey_blit");
		else
			$display("FAIL clipped_colorkey_blit");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/ccblit_pkg.sv
rtl/core/clipped_colorkey_blit.sv
dv/ccblit_checker.sv
dv/tb_top.sv
